// ===== rtl/core/noise_gate_with_hold_unit_defines.svh =====
// Assertion macros for the noise gate core.
// Needs clk and arst_n in the scope of each use; no other dependencies.
`ifndef NOISE_GATE_WITH_HOLD_UNIT_DEFINES_SVH
`define NOISE_GATE_WITH_HOLD_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define NGH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NGH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ngh_pkg.sv =====
// Shared types, constants and the control store of the noise gate core.
// No dependencies; used by the channel interfaces and the top level.
package ngh_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int HOLD_BITS      = 20;
	localparam int GAIN_BITS      = 24;
	localparam int FRAC_BITS      = 23;
	localparam int PHASE_BITS     = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = (HOLD_BITS > GAIN_BITS) ? HOLD_BITS : GAIN_BITS;
	localparam int PC_BITS        = 5;

	// datapath widths
	localparam int OPA_BITS  = ((SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS) + 1;
	localparam int OPB_BITS  = GAIN_BITS + 1;
	localparam int PROD_BITS = OPA_BITS + OPB_BITS;
	localparam int ACC_BITS  = PROD_BITS + 1;

	// Q1.23 constants
	localparam logic [GAIN_BITS-1:0] Q_ONE        = GAIN_BITS'(8388608);
	localparam logic [GAIN_BITS-1:0] Q_HALF       = GAIN_BITS'(4194304);
	localparam logic [GAIN_BITS-1:0] Q_ONE_M1     = GAIN_BITS'(8388607);
	localparam logic [GAIN_BITS-1:0] SNAP_OPEN    = GAIN_BITS'(8387770);
	localparam logic [GAIN_BITS-1:0] RANGE_MARGIN = GAIN_BITS'(8389);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GATE_ENABLE    = 3'd0,
		REG_OPEN_THRESHOLD = 3'd1,
		REG_ATTACK_COEF    = 3'd2,
		REG_RELEASE_COEF   = 3'd3,
		REG_FLOOR_GAIN     = 3'd4,
		REG_HOLD_LENGTH    = 3'd5
	} cfg_reg_t;

	typedef enum logic [4:0] {
		PH_CLOSED  = 5'b00001,
		PH_ATTACK  = 5'b00010,
		PH_OPEN    = 5'b00100,
		PH_HOLD    = 5'b01000,
		PH_RELEASE = 5'b10000
	} phase_t;

	localparam logic [PHASE_BITS-1:0] CODE_CLOSED  = 3'd0;
	localparam logic [PHASE_BITS-1:0] CODE_ATTACK  = 3'd1;
	localparam logic [PHASE_BITS-1:0] CODE_OPEN    = 3'd2;
	localparam logic [PHASE_BITS-1:0] CODE_HOLD    = 3'd3;
	localparam logic [PHASE_BITS-1:0] CODE_RELEASE = 3'd4;

	function automatic logic [PHASE_BITS-1:0] phase_code(phase_t ph);
		logic [PHASE_BITS-1:0] c;
		unique case (ph)
			PH_ATTACK:  c = CODE_ATTACK;
			PH_OPEN:    c = CODE_OPEN;
			PH_HOLD:    c = CODE_HOLD;
			PH_RELEASE: c = CODE_RELEASE;
			default:    c = CODE_CLOSED;
		endcase
		return c;
	endfunction

	// multiplier operand selects
	typedef enum logic [2:0] {
		OPA_X, OPA_ENVC, OPA_NENVC, OPA_NGAIN, OPA_REL, OPA_NREL, OPA_RANGE
	} opa_sel_t;

	typedef enum logic [2:0] {
		OPB_ENV, OPB_LVL, OPB_NATK, OPB_GAIN, OPB_RANGE, OPB_MARGIN
	} opb_sel_t;

	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

	typedef enum logic [1:0] {K_ZERO, K_HALF, K_ONE_M1} kon_sel_t;

	typedef enum logic [3:0] {
		WB_NONE, WB_ENV, WB_GATE, WB_ATTACK, WB_REARM, WB_LIMIT, WB_RELEASE,
		WB_BYPASS, WB_RESULT
	} wb_op_t;

	typedef enum logic [2:0] {
		C_NEVER, C_ALWAYS, C_ATTACK, C_RELEASE, C_OPEN_REQ
	} cond_t;

	typedef struct packed {
		opa_sel_t             opa;
		opb_sel_t             opb;
		acc_op_t              acc;
		kon_sel_t             kon;
		wb_op_t               wb;
		cond_t                cond;
		logic [PC_BITS-1:0]   target;
		logic                 wait_out;
		logic                 done;
	} ucode_t;

	localparam ucode_t UC_NOP = '{
		opa: OPA_X, opb: OPB_ENV, acc: ACC_HOLD, kon: K_ZERO, wb: WB_NONE,
		cond: C_NEVER, target: '0, wait_out: 1'b0, done: 1'b0
	};

	// program addresses
	localparam logic [PC_BITS-1:0] ST_E0  = 5'd0;
	localparam logic [PC_BITS-1:0] ST_E1  = 5'd1;
	localparam logic [PC_BITS-1:0] ST_E2  = 5'd2;
	localparam logic [PC_BITS-1:0] ST_E3  = 5'd3;
	localparam logic [PC_BITS-1:0] ST_E4  = 5'd4;
	localparam logic [PC_BITS-1:0] ST_E5  = 5'd5;
	localparam logic [PC_BITS-1:0] ST_A0  = 5'd6;
	localparam logic [PC_BITS-1:0] ST_A1  = 5'd7;
	localparam logic [PC_BITS-1:0] ST_A2  = 5'd8;
	localparam logic [PC_BITS-1:0] ST_R0  = 5'd9;
	localparam logic [PC_BITS-1:0] ST_R1  = 5'd10;
	localparam logic [PC_BITS-1:0] ST_R2  = 5'd11;
	localparam logic [PC_BITS-1:0] ST_R3  = 5'd12;
	localparam logic [PC_BITS-1:0] ST_R4  = 5'd13;
	localparam logic [PC_BITS-1:0] ST_BYP = 5'd14;
	localparam logic [PC_BITS-1:0] ST_O0  = 5'd15;
	localparam logic [PC_BITS-1:0] ST_O1  = 5'd16;
	localparam logic [PC_BITS-1:0] ST_O2  = 5'd17;

	// Control store. A product issued at step n is in the product register at n+1.
	function automatic ucode_t ngh_ucode(logic [PC_BITS-1:0] pc);
		ucode_t w;
		w = UC_NOP;
		unique case (pc)
			// envelope follower
			ST_E0: begin
				w.opa = OPA_ENVC; w.opb = OPB_ENV;
			end
			ST_E1: begin
				w.opa = OPA_NENVC; w.opb = OPB_LVL; w.acc = ACC_LOAD; w.kon = K_HALF;
			end
			ST_E2: begin
				w.acc = ACC_ADD;
			end
			ST_E3: begin
				w.wb = WB_ENV; w.cond = C_ATTACK; w.target = ST_A0;
			end
			ST_E4: begin
				w.cond = C_RELEASE; w.target = ST_R0;
			end
			ST_E5: begin
				w.wb = WB_GATE; w.cond = C_ALWAYS; w.target = ST_O0;
			end
			// attack ramp
			ST_A0: begin
				w.opa = OPA_NGAIN; w.opb = OPB_NATK;
			end
			ST_A1: begin
				w.acc = ACC_LOAD; w.kon = K_ONE_M1;
			end
			ST_A2: begin
				w.wb = WB_ATTACK; w.cond = C_ALWAYS; w.target = ST_O0;
			end
			// release decay
			ST_R0: begin
				w.opa = OPA_RANGE; w.opb = OPB_MARGIN; w.wb = WB_REARM;
				w.cond = C_OPEN_REQ; w.target = ST_O0;
			end
			ST_R1: begin
				w.opa = OPA_REL; w.opb = OPB_GAIN; w.acc = ACC_LOAD; w.kon = K_ZERO;
			end
			ST_R2: begin
				w.opa = OPA_NREL; w.opb = OPB_RANGE; w.wb = WB_LIMIT;
				w.acc = ACC_LOAD; w.kon = K_ZERO;
			end
			ST_R3: begin
				w.acc = ACC_ADD;
			end
			ST_R4: begin
				w.wb = WB_RELEASE; w.cond = C_ALWAYS; w.target = ST_O0;
			end
			// gate disabled
			ST_BYP: begin
				w.wb = WB_BYPASS; w.wait_out = 1'b1; w.done = 1'b1;
			end
			// output scaling
			ST_O0: begin
				w.opa = OPA_X; w.opb = OPB_GAIN;
			end
			ST_O1: begin
				w.acc = ACC_LOAD; w.kon = K_HALF;
			end
			ST_O2: begin
				w.wb = WB_RESULT; w.wait_out = 1'b1; w.done = 1'b1;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = ST_O0;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/ngh_channels_if.sv =====
// Valid/ready channel interfaces for the noise gate: audio in, result out.
// Depends on ngh_pkg for the field widths.
interface ngh_audio_if import ngh_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_sample;

	modport source (output valid, output in_sample, input ready);
	modport sink (input valid, input in_sample, output ready);
endinterface

interface ngh_result_if import ngh_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic [PHASE_BITS-1:0]         gate_phase;
	logic [GAIN_BITS-1:0]          applied_gain;

	modport source (output valid, output out_sample, output gate_phase,
		output applied_gain, input ready);
	modport sink (input valid, input out_sample, input gate_phase,
		input applied_gain, output ready);
endinterface

// ===== rtl/core/noise_gate_with_hold_unit.sv =====
// Noise gate with attack, hold and release; microcoded around one shared multiplier.
// Depends on ngh_pkg, ngh_channels_if.sv and noise_gate_with_hold_unit_defines.svh.
//
// Channel   Dir  Payload                                  Handshake
// audio     in   in_sample                                valid/ready
// result    out  out_sample, gate_phase, applied_gain     valid/ready
// cfg       in   cfg_index, cfg_data                      cfg_we, no back-pressure
//
// A sample is taken when audio.ready is high, i.e. when no sample is in work.
// The program then runs 9 to 13 steps with the gate enabled (closed/open/hold 9,
// attack 10, release 13, release re-opening 9) or 1 step when disabled, set by the
// control program length over the single registered multiplier. A new sample is
// taken only after the last step of the program has completed.
// The last step stalls while the result register still holds an untaken transaction.
// arst_n clears the sequencer, gate state and configuration registers.
`include "noise_gate_with_hold_unit_defines.svh"

module noise_gate_with_hold_unit import ngh_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	ngh_audio_if.sink                 audio,
	ngh_result_if.source              result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int LVL_SHR = (SAMPLE_BITS >= GAIN_BITS) ? SAMPLE_BITS - GAIN_BITS : 0;
	localparam int LVL_SHL = (SAMPLE_BITS < GAIN_BITS) ? GAIN_BITS - SAMPLE_BITS : 0;
	localparam int QW      = ACC_BITS - FRAC_BITS;
	localparam logic signed [QW-1:0] QMAX = QW'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [QW-1:0] QMIN = QW'(-(longint'(1) <<< (SAMPLE_BITS - 1)));

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic                 enable_q;
	logic [GAIN_BITS-1:0] thr_q, atk_q, rel_q, floor_q;
	logic [HOLD_BITS-1:0] hold_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			thr_q      <= '0;
			atk_q      <= '0;
			rel_q      <= '0;
			floor_q    <= '0;
			hold_len_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GATE_ENABLE:    enable_q   <= cfg_data[0];
				REG_OPEN_THRESHOLD: thr_q      <= cfg_data[GAIN_BITS-1:0];
				REG_ATTACK_COEF:    atk_q      <= cfg_data[GAIN_BITS-1:0];
				REG_RELEASE_COEF:   rel_q      <= cfg_data[GAIN_BITS-1:0];
				REG_FLOOR_GAIN:     floor_q    <= cfg_data[GAIN_BITS-1:0];
				REG_HOLD_LENGTH:    hold_len_q <= cfg_data[HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// coefficients and floor are clipped to unity where used; threshold is raw
	logic [GAIN_BITS-1:0] atk_s, rel_s, range_s;
	assign atk_s   = (atk_q > Q_ONE) ? Q_ONE : atk_q;
	assign rel_s   = (rel_q > Q_ONE) ? Q_ONE : rel_q;
	assign range_s = (floor_q > Q_ONE) ? Q_ONE : floor_q;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	logic               busy_q;
	logic [PC_BITS-1:0] pc_q;
	ucode_t             uc;
	logic               accept, stall, step_en, taken;

	// gate state
	logic [GAIN_BITS-1:0] env_q, gain_q;
	phase_t               phase_q;
	logic [HOLD_BITS-1:0] hold_q;
	logic                 open_req;

	logic res_valid_q;

	assign uc           = ngh_ucode(pc_q);
	assign audio.ready  = !busy_q;
	assign accept       = audio.valid && !busy_q;
	assign stall        = uc.wait_out && res_valid_q && !result.ready;
	assign step_en      = busy_q && !stall;
	assign open_req     = (env_q >= thr_q);

	always_comb begin
		unique case (uc.cond)
			C_ALWAYS:   taken = 1'b1;
			C_ATTACK:   taken = (phase_q == PH_ATTACK);
			C_RELEASE:  taken = (phase_q == PH_RELEASE);
			C_OPEN_REQ: taken = open_req;
			default:    taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= ST_E0;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= enable_q ? ST_E0 : ST_BYP;
		end else if (step_en) begin
			if (uc.done) begin
				busy_q <= 1'b0;
			end
			pc_q <= taken ? uc.target : pc_q + PC_BITS'(1);
		end
	end

	// ---------------------------------------------------------------
	// Datapath: operand muxes, multiplier, accumulator
	// ---------------------------------------------------------------
	logic signed [SAMPLE_BITS-1:0]   x_q;
	logic [GAIN_BITS-1:0]            lvl_q;
	logic [SAMPLE_BITS-1:0]          mag;
	logic [SAMPLE_BITS+GAIN_BITS-1:0] mag_wide;
	logic [GAIN_BITS-1:0]            lvl_in;
	logic [GAIN_BITS-1:0]            envc;
	logic signed [OPA_BITS-1:0]      opa;
	logic signed [OPB_BITS-1:0]      opb;
	logic signed [PROD_BITS-1:0]     prod_q;
	logic signed [ACC_BITS-1:0]      acc_q;
	logic [GAIN_BITS-1:0]            kval;
	logic [GAIN_BITS-1:0]            acc_frac;

	// sample magnitude scaled onto the Q1.23 level scale
	assign mag      = audio.in_sample[SAMPLE_BITS-1] ?
		SAMPLE_BITS'(~audio.in_sample + 1'b1) : SAMPLE_BITS'(audio.in_sample);
	assign mag_wide = (SAMPLE_BITS + GAIN_BITS)'(mag);
	assign lvl_in   = GAIN_BITS'((mag_wide >> LVL_SHR) << LVL_SHL);

	// rising envelope uses the attack coefficient, otherwise release
	assign envc     = (lvl_q > env_q) ? atk_s : rel_s;
	assign acc_frac = acc_q[FRAC_BITS +: GAIN_BITS];

	always_comb begin
		unique case (uc.opa)
			OPA_X:     opa = OPA_BITS'(x_q);
			OPA_ENVC:  opa = OPA_BITS'(envc);
			OPA_NENVC: opa = OPA_BITS'(Q_ONE - envc);
			OPA_NGAIN: opa = OPA_BITS'(Q_ONE - gain_q);
			OPA_REL:   opa = OPA_BITS'(rel_s);
			OPA_NREL:  opa = OPA_BITS'(Q_ONE - rel_s);
			OPA_RANGE: opa = OPA_BITS'(range_s);
			default:   opa = '0;
		endcase
	end

	always_comb begin
		unique case (uc.opb)
			OPB_ENV:    opb = OPB_BITS'(env_q);
			OPB_LVL:    opb = OPB_BITS'(lvl_q);
			OPB_NATK:   opb = OPB_BITS'(Q_ONE - atk_s);
			OPB_GAIN:   opb = OPB_BITS'(gain_q);
			OPB_RANGE:  opb = OPB_BITS'(range_s);
			OPB_MARGIN: opb = OPB_BITS'(RANGE_MARGIN);
			default:    opb = '0;
		endcase
	end

	always_comb begin
		unique case (uc.kon)
			K_HALF:   kval = Q_HALF;
			K_ONE_M1: kval = Q_ONE_M1;
			default:  kval = '0;
		endcase
	end

	// attack: ceil step toward unity, snap near unity
	logic [GAIN_BITS:0] gsum;
	logic               snap;
	assign gsum = (gain_q < Q_ONE) ? ({1'b0, gain_q} + {1'b0, acc_frac}) : {1'b0, gain_q};
	assign snap = (gsum >= {1'b0, SNAP_OPEN});

	// release: closes once within the floor margin
	logic [GAIN_BITS:0] lim_q;
	logic               rel_done;
	assign rel_done = ({1'b0, acc_frac} <= lim_q);

	// output rounding (half up, arithmetic shift) and saturation
	logic signed [QW-1:0]          q_full;
	logic signed [SAMPLE_BITS-1:0] q_sat;
	assign q_full = $signed(acc_q[ACC_BITS-1:FRAC_BITS]);

	always_comb begin
		priority if (q_full > QMAX) begin
			q_sat = QMAX[SAMPLE_BITS-1:0];
		end else if (q_full < QMIN) begin
			q_sat = QMIN[SAMPLE_BITS-1:0];
		end else begin
			q_sat = q_full[SAMPLE_BITS-1:0];
		end
	end

	logic signed [SAMPLE_BITS-1:0] res_sample_q;
	logic [PHASE_BITS-1:0]         res_phase_q;
	logic [GAIN_BITS-1:0]          res_gain_q;

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		if (accept) begin
			x_q   <= audio.in_sample;
			lvl_q <= lvl_in;
		end
		if (step_en) begin
			unique case (uc.acc)
				ACC_LOAD: acc_q <= $signed(ACC_BITS'(prod_q)) + $signed(ACC_BITS'(kval));
				ACC_ADD:  acc_q <= acc_q + $signed(ACC_BITS'(prod_q));
				default: ;
			endcase
			unique case (uc.wb)
				WB_LIMIT: lim_q <= {1'b0, range_s} + {1'b0, acc_frac};
				WB_RESULT: begin
					res_sample_q <= q_sat;
					res_phase_q  <= phase_code(phase_q);
					res_gain_q   <= gain_q;
				end
				WB_BYPASS: begin
					res_sample_q <= x_q;
					res_phase_q  <= phase_code(phase_q);
					res_gain_q   <= Q_ONE;
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Gate state updates
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q   <= '0;
			gain_q  <= '0;
			phase_q <= PH_CLOSED;
			hold_q  <= '0;
		end else if (step_en) begin
			unique case (uc.wb)
				WB_ENV: env_q <= acc_frac;
				WB_GATE: begin
					unique case (phase_q)
						PH_OPEN: begin
							if (!open_req) begin
								phase_q <= (hold_q != '0) ? PH_HOLD : PH_RELEASE;
							end
						end
						PH_HOLD: begin
							if (open_req) begin
								phase_q <= PH_OPEN;
							end else if (hold_q <= HOLD_BITS'(1)) begin
								hold_q  <= '0;
								phase_q <= PH_RELEASE;
							end else begin
								hold_q <= hold_q - HOLD_BITS'(1);
							end
						end
						default: phase_q <= open_req ? PH_ATTACK : PH_CLOSED;
					endcase
				end
				WB_ATTACK: begin
					if (snap) begin
						gain_q  <= Q_ONE;
						phase_q <= PH_OPEN;
						hold_q  <= hold_len_q;
					end else begin
						gain_q <= gsum[GAIN_BITS-1:0];
					end
				end
				WB_REARM: begin
					if (open_req) begin
						phase_q <= PH_ATTACK;
					end
				end
				WB_RELEASE: begin
					if (rel_done) begin
						gain_q  <= range_s;
						phase_q <= PH_CLOSED;
					end else begin
						gain_q <= acc_frac;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_en && (uc.wb == WB_RESULT || uc.wb == WB_BYPASS)) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.out_sample   = res_sample_q;
	assign result.gate_phase   = res_phase_q;
	assign result.applied_gain = res_gain_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`NGH_ASSERT_SAME(a_levels_in_range, 1'b1, (env_q <= Q_ONE) && (gain_q <= Q_ONE), "level above unity")
	`NGH_ASSERT_SAME(a_hold_nonzero, phase_q == PH_HOLD, hold_q != '0, "hold phase with empty counter")
	`NGH_ASSERT_NEXT(a_stall_holds_pc, busy_q && stall, busy_q && $stable(pc_q), "program moved while stalled")
	`NGH_ASSERT_NEXT(a_entry_step, accept, busy_q && (pc_q == ST_E0 || pc_q == ST_BYP), "bad program entry")

endmodule

// ===== tb/sv/noise_gate_with_hold_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for noise_gate_with_hold_unit: directed table, then random phases.
// Depends on ngh_pkg, the ngh_audio_if / ngh_result_if interfaces and the unit itself.
module noise_gate_with_hold_unit_tb;
	import ngh_pkg::*;

	// wait after the final settle before the verdict; ample for draining
	localparam int DRAIN_CYCLES    = 32;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int NUM_ROUNDS      = 16;
	localparam int ITEMS_PER_ROUND = 118;
	localparam int NUM_ROWS        = 34;

	localparam longint S_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint S_MIN = -S_MAX - 1;

	// table columns
	localparam bit SMP = 1'b0;
	localparam bit CFG = 1'b1;
	localparam bit PRD = 1'b0;
	localparam bit TYP = 1'b1;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] out_sample;
		logic [PHASE_BITS-1:0]  gate_phase;
		logic [GAIN_BITS-1:0]   applied_gain;
	} gate_out_t;

	typedef struct packed {
		logic                     is_cfg;
		logic                     typed;
		cfg_reg_t                 reg_idx;
		logic [CFG_DATA_BITS-1:0] value;
		logic [SAMPLE_BITS-1:0]   exp_out;
		logic [PHASE_BITS-1:0]    exp_ph;
		logic [GAIN_BITS-1:0]     exp_gain;
	} stim_row_t;

	typedef enum logic [1:0] {SEG_LOUD, SEG_QUIET, SEG_NOISE, SEG_EDGE} seg_kind_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	ngh_audio_if  audio_ch ();
	ngh_result_if result_ch ();

	// predictor copy of the control registers
	logic                 en_r;
	logic [GAIN_BITS-1:0] thr_r, atk_r, rel_r, floor_r;
	logic [HOLD_BITS-1:0] hold_len_r;

	// predictor copy of the gate state
	logic [GAIN_BITS-1:0]  env_lvl;
	logic [GAIN_BITS-1:0]  gate_gain;
	logic [PHASE_BITS-1:0] gate_ph;
	logic [HOLD_BITS-1:0]  hold_left;

	gate_out_t   awaited[$];   // expected result transactions, oldest first
	int          mismatches = 0;
	int unsigned cycles = 0;
	bit          calm;         // no idling on either side while set
	int          seg_left;
	seg_kind_t   seg_kind;

	stim_row_t   directed_rows [NUM_ROWS];

	noise_gate_with_hold_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.audio     (audio_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Advance the gate by one sample and return what the unit should emit.
	function automatic gate_out_t gate_sample(logic signed [SAMPLE_BITS-1:0] x);
		gate_out_t           r;
		longint              xs, p, q;
		longint unsigned     lvl, env, g, atk, rel, rng, c;
		xs = x;
		if (!en_r) begin
			// bypass: sample through, unity gain reported, state frozen
			r.out_sample   = x;
			r.gate_phase   = gate_ph;
			r.applied_gain = Q_ONE;
			return r;
		end
		lvl = (xs < 0) ? -xs : xs;
		atk = (atk_r > Q_ONE) ? Q_ONE : atk_r;
		rel = (rel_r > Q_ONE) ? Q_ONE : rel_r;
		rng = (floor_r > Q_ONE) ? Q_ONE : floor_r;
		g   = gate_gain;

		// peak follower, round half up
		c   = (lvl > env_lvl) ? atk : rel;
		env = (c * env_lvl + (Q_ONE - c) * lvl + Q_HALF) >> FRAC_BITS;

		case (gate_ph)
			CODE_ATTACK: begin
				if (g < Q_ONE)
					g = g + (((Q_ONE - g) * (Q_ONE - atk) + Q_ONE_M1) >> FRAC_BITS);
				if (g >= SNAP_OPEN) begin
					g         = Q_ONE;
					gate_ph   = CODE_OPEN;
					hold_left = hold_len_r;
				end
			end
			CODE_OPEN: begin
				if (env < thr_r)
					gate_ph = (hold_left != '0) ? CODE_HOLD : CODE_RELEASE;
			end
			CODE_HOLD: begin
				if (env >= thr_r) begin
					gate_ph = CODE_OPEN;
				end else if (hold_left <= 1) begin
					hold_left = '0;
					gate_ph   = CODE_RELEASE;
				end else begin
					hold_left = hold_left - 1'b1;
				end
			end
			CODE_RELEASE: begin
				if (env >= thr_r) begin
					gate_ph = CODE_ATTACK;
				end else begin
					g = (rel * g + (Q_ONE - rel) * rng) >> FRAC_BITS;
					if (g <= rng + ((rng * RANGE_MARGIN) >> FRAC_BITS)) begin
						g       = rng;
						gate_ph = CODE_CLOSED;
					end
				end
			end
			default: begin
				gate_ph = CODE_CLOSED;
				if (env >= thr_r)
					gate_ph = CODE_ATTACK;
			end
		endcase

		env_lvl   = env[GAIN_BITS-1:0];
		gate_gain = g[GAIN_BITS-1:0];

		// round half toward +inf, then clip to the sample range
		p = xs * longint'(g) + longint'(Q_HALF);
		q = p >>> FRAC_BITS;
		if (q > S_MAX) q = S_MAX;
		if (q < S_MIN) q = S_MIN;

		r.out_sample   = q[SAMPLE_BITS-1:0];
		r.gate_phase   = gate_ph;
		r.applied_gain = g[GAIN_BITS-1:0];
		return r;
	endfunction

	// Coefficient / floor value: extremes, just under unity, or anywhere in range.
	function automatic logic [CFG_DATA_BITS-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return CFG_DATA_BITS'(Q_ONE);
			2:       return CFG_DATA_BITS'(24'hFFFFFF);
			3:       return CFG_DATA_BITS'(Q_ONE - $urandom_range(1, 64));
			default: return CFG_DATA_BITS'($urandom_range(0, Q_ONE));
		endcase
	endfunction

	// Random audio: alternating loud and quiet stretches so the gate walks
	// through all its phases, with some noise and full-scale edges mixed in.
	function automatic logic [SAMPLE_BITS-1:0] next_sample();
		logic [SAMPLE_BITS-1:0] mag;
		if (seg_left == 0) begin
			seg_left = $urandom_range(1, 40);
			case ($urandom_range(0, 9))
				0, 1:    seg_kind = SEG_NOISE;
				2:       seg_kind = SEG_EDGE;
				default: seg_kind = (seg_kind == SEG_LOUD) ? SEG_QUIET : SEG_LOUD;
			endcase
		end
		seg_left--;
		case (seg_kind)
			SEG_LOUD:  mag = SAMPLE_BITS'($urandom_range(24'h100000, 24'h7FFFFF));
			SEG_QUIET: mag = ($urandom_range(0, 2) == 0) ? '0 :
				SAMPLE_BITS'($urandom_range(0, 24'h000FFF));
			SEG_NOISE: return SAMPLE_BITS'($urandom());
			default: begin
				case ($urandom_range(0, 3))
					0:       return 24'h800000;
					1:       return 24'h7FFFFF;
					2:       return 24'hFFFFFF;
					default: return '0;
				endcase
			end
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Offer one audio transaction; on acceptance queue what should come back.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] x, input bit use_typed,
			input gate_out_t typed);
		gate_out_t e;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			audio_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		audio_ch.valid     <= 1'b1;
		audio_ch.in_sample <= x;
		do @(posedge clk); while (!audio_ch.ready);
		e = gate_sample(x);
		if (use_typed)
			e = typed;
		awaited.push_back(e);
	endtask

	// Stop offering and wait until every queued result has come back.
	task automatic settle();
		@(negedge clk);
		audio_ch.valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_GATE_ENABLE:    en_r       = val[0];
			REG_OPEN_THRESHOLD: thr_r      = val[GAIN_BITS-1:0];
			REG_ATTACK_COEF:    atk_r      = val[GAIN_BITS-1:0];
			REG_RELEASE_COEF:   rel_r      = val[GAIN_BITS-1:0];
			REG_FLOOR_GAIN:     floor_r    = val[GAIN_BITS-1:0];
			REG_HOLD_LENGTH:    hold_len_r = val[HOLD_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: random stall bursts unless calm.
	initial begin : result_sink
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare every result transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		gate_out_t e;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (awaited.size() == 0) begin
				$display("%0t ns: result with none expected: out %h phase %0d gain %h",
					$time, result_ch.out_sample, result_ch.gate_phase,
					result_ch.applied_gain);
				mismatches++;
			end else begin
				e = awaited.pop_front();
				if (result_ch.out_sample !== e.out_sample) begin
					$display("%0t ns: out_sample expected %h got %h",
						$time, e.out_sample, result_ch.out_sample);
					mismatches++;
				end
				if (result_ch.gate_phase !== e.gate_phase) begin
					$display("%0t ns: gate_phase expected %0d got %0d",
						$time, e.gate_phase, result_ch.gate_phase);
					mismatches++;
				end
				if (result_ch.applied_gain !== e.applied_gain) begin
					$display("%0t ns: applied_gain expected %h got %h",
						$time, e.applied_gain, result_ch.applied_gain);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: far beyond the slowest legal run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d results outstanding", $time, awaited.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		gate_out_t                want;
		logic [CFG_DATA_BITS-1:0] en_word;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_GATE_ENABLE;
		cfg_data           = '0;
		audio_ch.valid     = 1'b0;
		audio_ch.in_sample = '0;
		calm               = 1'b0;
		seg_left           = 0;
		seg_kind           = SEG_QUIET;

		// state after reset
		en_r       = 1'b0;
		thr_r      = '0;
		atk_r      = '0;
		rel_r      = '0;
		floor_r    = '0;
		hold_len_r = '0;
		env_lvl    = '0;
		gate_gain  = '0;
		gate_ph    = CODE_CLOSED;
		hold_left  = '0;

		// Directed walk: bypass after reset, then one trip closed -> attack -> open ->
		// hold (threshold met exactly, hold recovering to open) -> release -> re-attack,
		// then out-of-range settings and a disabled freeze.
		directed_rows = '{
			// bypass straight after reset: sample through, unity gain, closed
			'{SMP, TYP, REG_GATE_ENABLE, 24'h800000, 24'h800000, CODE_CLOSED, Q_ONE},
			'{SMP, TYP, REG_GATE_ENABLE, 24'h7FFFFF, 24'h7FFFFF, CODE_CLOSED, Q_ONE},
			'{SMP, TYP, REG_GATE_ENABLE, 24'h000000, 24'h000000, CODE_CLOSED, Q_ONE},
			'{CFG, PRD, REG_HOLD_LENGTH,    24'h000002, '0, '0, '0},
			'{CFG, PRD, REG_FLOOR_GAIN,     24'h080000, '0, '0, '0},
			'{CFG, PRD, REG_RELEASE_COEF,   24'h400000, '0, '0, '0},
			'{CFG, PRD, REG_ATTACK_COEF,    24'h000000, '0, '0, '0},
			'{CFG, PRD, REG_OPEN_THRESHOLD, 24'h100000, '0, '0, '0},
			'{CFG, PRD, REG_GATE_ENABLE,    24'h000001, '0, '0, '0},
			// silence keeps it shut with zero gain
			'{SMP, TYP, REG_GATE_ENABLE, 24'h000000, 24'h000000, CODE_CLOSED, 24'h000000},
			// full scale opens attack; gain moves only from the next sample
			'{SMP, TYP, REG_GATE_ENABLE, 24'h7FFFFF, 24'h000000, CODE_ATTACK, 24'h000000},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h7FFFFF, '0, '0, '0},
			// envelope halves each sample; the third lands exactly on the threshold
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000000, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000000, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000000, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000000, '0, '0, '0},
			// recovery during hold goes back to open
			'{SMP, PRD, REG_GATE_ENABLE, 24'h180000, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000000, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000000, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000000, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000000, '0, '0, '0},
			// most negative sample during release re-attacks
			'{SMP, PRD, REG_GATE_ENABLE, 24'h800000, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'hFFFFFF, '0, '0, '0},
			// attack coefficient and floor above unity, release at unity, threshold unreachable, longest hold
			'{CFG, PRD, REG_ATTACK_COEF,    24'hFFFFFF, '0, '0, '0},
			'{CFG, PRD, REG_RELEASE_COEF,   24'h800000, '0, '0, '0},
			'{CFG, PRD, REG_OPEN_THRESHOLD, 24'hFFFFFF, '0, '0, '0},
			'{CFG, PRD, REG_FLOOR_GAIN,     24'hFFFFFF, '0, '0, '0},
			'{CFG, PRD, REG_HOLD_LENGTH,    24'h0FFFFF, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h7FFFFF, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h123456, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000000, '0, '0, '0},
			// disabled: phase reads back frozen
			'{CFG, PRD, REG_GATE_ENABLE,    24'hFFFFFE, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'h000001, '0, '0, '0},
			'{SMP, PRD, REG_GATE_ENABLE, 24'hEDCBA9, '0, '0, '0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				settle();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
			end else begin
				want = '{directed_rows[i].exp_out, directed_rows[i].exp_ph,
					directed_rows[i].exp_gain};
				send_sample(directed_rows[i].value, directed_rows[i].typed, want);
			end
		end

		// Random rounds: fresh settings each time, gate state carried over.
		// The last two rounds run without idling on either side.
		for (int round = 0; round < NUM_ROUNDS; round++) begin
			settle();
			calm = (round >= NUM_ROUNDS - 2) || ($urandom_range(0, 4) == 0);
			en_word    = CFG_DATA_BITS'($urandom());
			en_word[0] = ($urandom_range(0, 5) != 0);
			case ($urandom_range(0, 5))
				0:       write_reg(REG_OPEN_THRESHOLD, '0);
				1:       write_reg(REG_OPEN_THRESHOLD, CFG_DATA_BITS'(Q_ONE));
				2:       write_reg(REG_OPEN_THRESHOLD, CFG_DATA_BITS'(24'hFFFFFF));
				default: write_reg(REG_OPEN_THRESHOLD,
					CFG_DATA_BITS'($urandom_range(24'h010000, 24'h600000)));
			endcase
			write_reg(REG_ATTACK_COEF, pick_coef());
			write_reg(REG_RELEASE_COEF, pick_coef());
			write_reg(REG_FLOOR_GAIN, pick_coef());
			case ($urandom_range(0, 7))
				0:       write_reg(REG_HOLD_LENGTH, '0);
				1:       write_reg(REG_HOLD_LENGTH, CFG_DATA_BITS'(1));
				2:       write_reg(REG_HOLD_LENGTH, CFG_DATA_BITS'(20'hFFFFF));
				default: write_reg(REG_HOLD_LENGTH, CFG_DATA_BITS'($urandom_range(2, 30)));
			endcase
			write_reg(REG_GATE_ENABLE, en_word);
			repeat (ITEMS_PER_ROUND)
				send_sample(next_sample(), PRD, '0);
		end

		settle();
		// let any stray transaction surface before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ngh_pkg.sv
rtl/core/ngh_channels_if.sv
rtl/core/noise_gate_with_hold_unit.sv
tb/sv/noise_gate_with_hold_unit_tb.sv
